/* rtl/multi_root_trie_prefix_max_assert.svh */
// Assertion macros for the multi-root trie checker.
`ifndef MULTI_ROOT_TRIE_PREFIX_MAX_ASSERT_SVH
`define MULTI_ROOT_TRIE_PREFIX_MAX_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define MRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mrtrie_pkg.sv */
// Shared widths, opcodes and status codes of the multi-root trie.
package mrtrie_pkg;

    localparam int OPCODE_W = 2;
    localparam int ROOT_W   = 12;
    localparam int SYMBOL_W = 5;
    localparam int VALUE_W  = 16;
    localparam int ANSWER_W = 17;

    typedef logic [OPCODE_W-1:0] t_opcode;

    localparam t_opcode OP_NEW_ROOT = 2'd0;
    localparam t_opcode OP_INSERT   = 2'd1;
    localparam t_opcode OP_QUERY    = 2'd2;
    localparam t_opcode OP_NONE     = 2'd3;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

endpackage

/* rtl/multi_root_trie_prefix_max.sv */
// A new root request answers in the next cycle and leaves the block ready at once.
// Insert and query requests hold busy through S_ROOT (first item only, for root
// reduction), S_EXEC, and S_ALLOC, S_RAISE or S_QNEXT when the walk allocates or steps;
// the strobe, raised only for a last item, follows the last busy state.
// Each step reads a node row, modifies it and writes it back; requests are taken only while idle.
// Reset: synchronous; after release the S_INIT state clears the row of node 1.
module multi_root_trie_prefix_max #(
    parameter int NODES    = 4096,
    parameter int ALPHABET = 26,
    parameter int MAX_LEN  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mrtrie_pkg::t_opcode               i_opcode,
    input  logic [mrtrie_pkg::ROOT_W-1:0]     i_root,
    input  logic [mrtrie_pkg::SYMBOL_W-1:0]   i_symbol,
    input  logic [mrtrie_pkg::VALUE_W-1:0]    i_value,
    input  logic                              i_first,
    input  logic                              i_last,
    input  logic                              i_empty_req,
    output logic                              o_valid,
    output logic                              o_status,
    output logic [mrtrie_pkg::ANSWER_W-1:0]   o_answer
);

    localparam int AW    = $clog2(NODES);
    localparam int AW1   = AW + 1;
    localparam int SW    = $clog2(ALPHABET);
    localparam int DW    = $clog2(MAX_LEN + 1);
    localparam int VW    = mrtrie_pkg::VALUE_W;
    localparam int QW    = ((DW > VW) ? DW : VW) + 1;
    localparam int LW    = ALPHABET * AW;
    localparam int ROW_W = VW + LW;
    localparam int ANW   = mrtrie_pkg::ANSWER_W;

    localparam logic [AW:0]   NODES_C    = AW1'(NODES);
    localparam logic [AW:0]   FIRST_FREE = AW1'(2);
    localparam logic [AW-1:0] NODE_ONE   = AW'(1);
    localparam logic [DW-1:0] MAX_C      = DW'(MAX_LEN);
    localparam logic [8:0]    ALPH_C     = 9'(ALPHABET);

    // Sequencer states.
    localparam logic [2:0] S_INIT  = 3'd0;  // clear the row of node 1
    localparam logic [2:0] S_IDLE  = 3'd1;  // take a request
    localparam logic [2:0] S_ROOT  = 3'd2;  // reduced root ready, read its row
    localparam logic [2:0] S_EXEC  = 3'd3;  // cursor row in hand, step the walk
    localparam logic [2:0] S_ALLOC = 3'd4;  // write the freshly taken child row
    localparam logic [2:0] S_RAISE = 3'd5;  // raise the best of an existing child
    localparam logic [2:0] S_QNEXT = 3'd6;  // score the child reached by a query

    // Control state.
    logic [2:0]     r_state, n_state;
    logic [AW:0]    r_free,  n_free;
    logic [AW-1:0]  r_cur,   n_cur;
    logic           r_dead,  n_dead;
    logic [DW-1:0]  r_depth, n_depth;
    logic [QW-1:0]  r_qbest, n_qbest;
    logic           r_valid, n_valid;
    logic           r_status, n_status;
    logic [ANW-1:0] r_answer, n_answer;

    // Request held for the length of its walk step.
    mrtrie_pkg::t_opcode               r_op;
    logic [mrtrie_pkg::SYMBOL_W-1:0]   r_sym;
    logic [VW-1:0]                     r_val;
    logic                              r_first;
    logic                              r_last;
    logic                              r_empty;

    // Memory port.
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [ROW_W-1:0]  w_rd_data;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [ROW_W-1:0]  w_wr_data;

    // Walk datapath.
    logic              w_accept;
    logic [AW-1:0]     w_root_rem;
    logic              w_sym_ok;
    logic [SW-1:0]     w_slot;
    logic [VW-1:0]     w_best;
    logic [VW-1:0]     w_val_max;
    logic [VW-1:0]     w_first_best;
    logic [AW-1:0]     w_link;
    logic [LW-1:0]     w_links;
    logic [LW-1:0]     w_links_upd;
    logic              w_full;
    logic              w_go_ins;
    logic              w_go_qry;
    logic [QW-1:0]     w_qb0;
    logic [QW-1:0]     w_cand;
    logic [QW-1:0]     w_qmax;

    assign w_accept = start && !busy;

    // A row holds the node best on top and one child link per symbol below;
    // a zero link means no child, since node 0 is never handed out.
    mrtrie_mem #(
        .DEPTH (NODES),
        .WIDTH (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Root index folded into the pool; ready in the cycle after the request.
    mrtrie_rootmod #(
        .NODES (NODES)
    ) u_rootmod (
        .i_clk  (i_clk),
        .i_load (w_accept),
        .i_root (i_root),
        .o_rem  (w_root_rem)
    );

    // Decode the row read back for the cursor (or the child just reached).
    // An out-of-alphabet symbol points at slot zero; its link is never used.
    assign w_sym_ok     = 9'(r_sym) < ALPH_C;
    assign w_slot       = w_sym_ok ? SW'(r_sym) : '0;
    assign w_best       = w_rd_data[ROW_W-1 -: VW];
    assign w_links      = w_rd_data[LW-1:0];
    assign w_link       = w_links[w_slot*AW +: AW];
    assign w_val_max    = (r_val > w_best) ? r_val : w_best;
    assign w_first_best = r_first ? w_val_max : w_best;
    assign w_full       = r_free >= NODES_C;
    assign w_go_ins     = !r_empty && !r_dead && w_sym_ok;
    assign w_go_qry     = !r_empty && !r_dead;
    assign w_qb0        = r_first ? QW'(w_best) : r_qbest;
    assign w_cand       = QW'(r_depth) + QW'(w_best);
    assign w_qmax       = (w_cand > r_qbest) ? w_cand : r_qbest;

    // Link the next free node into the cursor row.
    always_comb begin
        w_links_upd = w_links;
        w_links_upd[w_slot*AW +: AW] = r_free[AW-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_cur     = r_cur;
        n_dead    = r_dead;
        n_depth   = r_depth;
        n_qbest   = r_qbest;
        n_valid   = 1'b0;
        n_status  = mrtrie_pkg::ST_OK;
        n_answer  = '0;
        w_rd_en   = 1'b0;
        w_rd_addr = r_cur;
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur;
        w_wr_data = '0;

        unique case (r_state)
            S_INIT: begin
                // Node 1 is the first root: empty row, best zero.
                w_wr_en   = 1'b1;
                w_wr_addr = NODE_ONE;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_opcode) inside
                        mrtrie_pkg::OP_NEW_ROOT: begin
                            // Hand out a cleared node, or flag the full pool.
                            n_valid = 1'b1;
                            if (w_full) begin
                                n_status = mrtrie_pkg::ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = r_free[AW-1:0];
                                n_free    = r_free + 1'b1;
                                n_answer  = ANW'(r_free);
                            end
                        end
                        mrtrie_pkg::OP_INSERT, mrtrie_pkg::OP_QUERY: begin
                            // A first item restarts at the root; others carry on.
                            if (i_first) begin
                                n_state = S_ROOT;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_cur;
                                n_state   = S_EXEC;
                            end
                        end
                        mrtrie_pkg::OP_NONE: begin
                        end
                    endcase
                end
            end
            S_ROOT: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_root_rem;
                n_cur     = w_root_rem;
                n_dead    = 1'b0;
                if (r_op == mrtrie_pkg::OP_QUERY) begin
                    n_depth = '0;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = r_last;
                if (r_op == mrtrie_pkg::OP_INSERT) begin
                    // Write the cursor row back, its best raised on a first item.
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cur;
                    w_wr_data = {w_first_best, w_links};
                    n_status  = r_dead ? mrtrie_pkg::ST_FULL : mrtrie_pkg::ST_OK;
                    if (w_go_ins) begin
                        if (w_link == '0) begin
                            if (w_full) begin
                                // Drop the rest of the string; earlier raises stay.
                                n_dead   = 1'b1;
                                n_status = mrtrie_pkg::ST_FULL;
                            end else begin
                                w_wr_data = {w_first_best, w_links_upd};
                                n_free    = r_free + 1'b1;
                                n_cur     = r_free[AW-1:0];
                                n_valid   = 1'b0;
                                n_state   = S_ALLOC;
                            end
                        end else begin
                            // Fetch the child while the parent goes back.
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_link;
                            n_cur     = w_link;
                            n_valid   = 1'b0;
                            n_state   = S_RAISE;
                        end
                    end
                end else begin
                    n_qbest  = w_qb0;
                    n_answer = ANW'(w_qb0);
                    if (w_go_qry) begin
                        if (!w_sym_ok || w_link == '0) begin
                            n_dead = 1'b1;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_link;
                            n_cur     = w_link;
                            n_depth   = (r_depth < MAX_C) ? r_depth + 1'b1 : r_depth;
                            n_valid   = 1'b0;
                            n_state   = S_QNEXT;
                        end
                    end
                end
            end
            S_ALLOC: begin
                // Fresh node: empty links, best is the inserted value.
                w_wr_en   = 1'b1;
                w_wr_addr = r_cur;
                w_wr_data = {r_val, LW'(0)};
                n_valid   = r_last;
                n_state   = S_IDLE;
            end
            S_RAISE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cur;
                w_wr_data = {w_val_max, w_links};
                n_valid   = r_last;
                n_state   = S_IDLE;
            end
            S_QNEXT: begin
                n_qbest  = w_qmax;
                n_answer = ANW'(w_qmax);
                n_valid  = r_last;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_free   <= FIRST_FREE;
            r_cur    <= '0;
            r_dead   <= 1'b0;
            r_depth  <= '0;
            r_qbest  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_cur    <= n_cur;
            r_dead   <= n_dead;
            r_depth  <= n_depth;
            r_qbest  <= n_qbest;
            r_valid  <= n_valid;
        end
    end

    // Hold the request and the result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_answer <= n_answer;
        if (w_accept) begin
            r_op    <= i_opcode;
            r_sym   <= i_symbol;
            r_val   <= i_value;
            r_first <= i_first;
            r_last  <= i_last;
            r_empty <= i_empty_req;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_answer = r_answer;

endmodule

/* rtl/mrtrie_mem.sv */
// Node row memory: one write port, one read port, registered read data.
module mrtrie_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 328
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mrtrie_rootmod.sv */
// Root index reduction modulo the pool size by reciprocal multiplication.
module mrtrie_rootmod #(
    parameter int NODES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic [mrtrie_pkg::ROOT_W-1:0]    i_root,
    output logic [$clog2(NODES)-1:0]         o_rem
);

    localparam int RW  = mrtrie_pkg::ROOT_W;
    localparam int AW  = $clog2(NODES);
    localparam int SH  = RW + AW;
    localparam int M   = ((1 << SH) + NODES - 1) / NODES;
    localparam int MW  = $clog2(M + 1);
    localparam int PW  = RW + MW;
    localparam int DW2 = RW + AW + 1;
    localparam logic [PW-1:0]  M_C = PW'(M);
    localparam logic [DW2-1:0] D_C = DW2'(NODES);

    logic [PW-1:0]  r_prod;
    logic [RW-1:0]  r_root;
    logic [RW-1:0]  w_quot;
    logic [DW2-1:0] w_qd;
    logic [DW2-1:0] w_rem;

    // Stage one: scale by the rounded-up reciprocal, exact for every root.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PW'(i_root) * M_C;
            r_root <= i_root;
        end
    end

    // Stage two: quotient back to a multiple, subtract for the remainder.
    assign w_quot = RW'(r_prod >> SH);
    assign w_qd   = DW2'(w_quot) * D_C;
    assign w_rem  = DW2'(r_root) - w_qd;
    assign o_rem  = AW'(w_rem);

endmodule

/* rtl/mrtrie_chk.sv */
// Port-level checker for the multi-root trie, bound to the top level.
`include "multi_root_trie_prefix_max_assert.svh"

module mrtrie_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input mrtrie_pkg::t_opcode i_opcode,
    input logic                o_valid
);

    `MRT_ASSERT_NEXT(a_new_root_answers, start && !busy && i_opcode == mrtrie_pkg::OP_NEW_ROOT, o_valid && !busy, "new root request did not answer in the next cycle")
    `MRT_ASSERT_NEXT(a_walk_goes_busy, start && !busy && (i_opcode == mrtrie_pkg::OP_INSERT || i_opcode == mrtrie_pkg::OP_QUERY), busy && !o_valid, "walk request did not occupy the block")
    `MRT_ASSERT(a_result_has_cause, o_valid |-> ($past(busy) || $past(start)), "result strobe without a request in progress")
    `MRT_ASSERT_NEXT(a_busy_bounded, busy && $past(busy) && $past(busy, 2) && $past(i_rst_n, 2), !busy, "block stayed busy longer than three cycles")

endmodule

bind multi_root_trie_prefix_max mrtrie_chk u_mrtrie_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid)
);
